[sv/msc_pkg.sv]
// Shared types and constants for the Menger section pixel classifier.
package msc_pkg;

    // Fixed field widths
    localparam int COORD_W     = 12;
    localparam int DEPTH_W     = 4;
    localparam int PATTERN_W   = 8;
    localparam int RECIP_W     = 25;
    localparam int GRAY_W      = 8;

    // Coordinate bits used and fraction precision (Q1.FRAC_BITS)
    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 24;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int PROD_W      = COORD_BITS + RECIP_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP   = 2'd2;

    // Register reset values
    localparam logic [DEPTH_W-1:0]   DEPTH_RESET   = 4'd4;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 8'd0;
    localparam logic [RECIP_W-1:0]   RECIP_RESET   = 25'd7675;

    // Gray values
    localparam logic [GRAY_W-1:0] GRAY_INSIDE  = 8'd0;
    localparam logic [GRAY_W-1:0] GRAY_OUTSIDE = 8'd230;

    // Middle-third digit
    localparam logic [1:0] DIGIT_MID = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic              is_inside;
        logic [GRAY_W-1:0] gray_level;
    } result_t;

    // Payload carried between pipeline stages
    typedef struct packed {
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
        logic              outside;
    } stage_t;

endpackage

[sv/msc_scale.sv]
// Input stage: scales both coordinates to saturated Q1.24 fractions.
module msc_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  msc_pkg::pixel_t          pixel,
    input  logic [msc_pkg::RECIP_W-1:0] recip,
    output logic                     out_valid,
    output msc_pkg::stage_t          out_stage
);
    import msc_pkg::*;

    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [PROD_W-1:0]     prod_x;
    logic [PROD_W-1:0]     prod_y;
    logic                  valid_reg;
    stage_t                stage_reg;
    stage_t                stage_next;

    // Unused high coordinate bits are masked off
    assign coord_x = pixel.pixel_x[COORD_BITS-1:0];
    assign coord_y = pixel.pixel_y[COORD_BITS-1:0];

    assign prod_x = PROD_W'(coord_x) * PROD_W'(recip);
    assign prod_y = PROD_W'(coord_y) * PROD_W'(recip);

    // Saturate at 1.0
    always_comb
    begin
        stage_next.frac_x  = (prod_x > PROD_W'(FRAC_ONE)) ? FRAC_ONE : prod_x[FRAC_W-1:0];
        stage_next.frac_y  = (prod_y > PROD_W'(FRAC_ONE)) ? FRAC_ONE : prod_y[FRAC_W-1:0];
        stage_next.outside = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[sv/msc_level.sv]
// One base-3 digit level: extracts a digit per coordinate and tests the level.
module msc_level #(
    parameter int LEVEL = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [msc_pkg::DEPTH_W-1:0]  depth_levels,
    input  logic [msc_pkg::PATTERN_W-1:0] section_pattern,
    input  logic                         in_valid,
    input  msc_pkg::stage_t              in_stage,
    output logic                         out_valid,
    output msc_pkg::stage_t              out_stage
);
    import msc_pkg::*;

    localparam int TRIP_W = FRAC_BITS + 2;

    logic [TRIP_W-1:0] trip_x;
    logic [TRIP_W-1:0] trip_y;
    logic [1:0]        digit_x;
    logic [1:0]        digit_y;
    logic              mid_x;
    logic              mid_y;
    logic              pat_bit;
    logic              active;
    logic              hit;
    logic              valid_reg;
    stage_t            stage_reg;
    stage_t            stage_next;

    // Levels beyond the pattern width see a zero pattern bit
    assign pat_bit = (LEVEL < PATTERN_W) ? section_pattern[LEVEL % PATTERN_W] : 1'b0;
    assign active  = {1'b0, depth_levels} > (DEPTH_W + 1)'(LEVEL);

    // 3 * frac as frac + 2 * frac
    assign trip_x = {1'b0, in_stage.frac_x} + {in_stage.frac_x, 1'b0};
    assign trip_y = {1'b0, in_stage.frac_y} + {in_stage.frac_y, 1'b0};

    assign digit_x = trip_x[TRIP_W-1:FRAC_BITS];
    assign digit_y = trip_y[TRIP_W-1:FRAC_BITS];
    assign mid_x   = (digit_x == DIGIT_MID);
    assign mid_y   = (digit_y == DIGIT_MID);

    // Two or more of the pattern bit and the two middle-third marks put the pixel outside
    assign hit = (pat_bit & mid_x) | (pat_bit & mid_y) | (mid_x & mid_y);

    always_comb
    begin
        stage_next.frac_x  = {1'b0, trip_x[FRAC_BITS-1:0]};
        stage_next.frac_y  = {1'b0, trip_y[FRAC_BITS-1:0]};
        stage_next.outside = in_stage.outside | (active & hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[sv/menger_section_pixel_classifier.sv]
// Top level: configuration registers, scale stage, digit-level pipeline, result register.
//
// Pixel classifier for a planar Menger sponge section. One pixel can be started
// every clock; busy is never raised. Each result appears on result with done high
// for one cycle, after passing through the coordinate scaling multiply register,
// one pipeline stage per base-3 digit level (the stage count is set by MAX_LEVELS,
// not by depth_levels), and one output register.
// Results come out in start order and cannot be held off, so the receiver must
// take each one in the cycle it is shown. Registers are written through
// cfg_write/cfg_index/cfg_data and should only change while no pixel is in flight.
module menger_section_pixel_classifier #(
    parameter int MAX_LEVELS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  msc_pkg::pixel_t               pixel,
    output logic                          done,
    output msc_pkg::result_t              result,
    input  logic                          cfg_write,
    input  logic [msc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msc_pkg::RECIP_W-1:0]   cfg_data
);
    import msc_pkg::*;

    logic [DEPTH_W-1:0]   depth_reg;
    logic [PATTERN_W-1:0] pattern_reg;
    logic [RECIP_W-1:0]   recip_reg;

    logic                 pipe_valid [MAX_LEVELS+1];
    stage_t               pipe_stage [MAX_LEVELS+1];

    logic                 done_reg;
    result_t              result_reg;
    result_t              result_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= DEPTH_RESET;
            pattern_reg <= PATTERN_RESET;
            recip_reg   <= RECIP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPTH:   depth_reg   <= cfg_data[DEPTH_W-1:0];
                REG_PATTERN: pattern_reg <= cfg_data[PATTERN_W-1:0];
                REG_RECIP:   recip_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Pipeline never stalls
    assign busy = 1'b0;

    msc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel     (pixel),
        .recip     (recip_reg),
        .out_valid (pipe_valid[0]),
        .out_stage (pipe_stage[0])
    );

    // One stage per digit level
    for (genvar g = 0; g < MAX_LEVELS; g++)
    begin : g_level
        msc_level #(
            .LEVEL (g)
        ) u_level (
            .clk             (clk),
            .rst_n           (rst_n),
            .depth_levels    (depth_reg),
            .section_pattern (pattern_reg),
            .in_valid        (pipe_valid[g]),
            .in_stage        (pipe_stage[g]),
            .out_valid       (pipe_valid[g+1]),
            .out_stage       (pipe_stage[g+1])
        );
    end

    // Result register
    always_comb
    begin
        result_next.is_inside  = ~pipe_stage[MAX_LEVELS].outside;
        result_next.gray_level = pipe_stage[MAX_LEVELS].outside ? GRAY_OUTSIDE : GRAY_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pipe_valid[MAX_LEVELS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[sv/msc_checker.sv]
// Port-level checker for the Menger section pixel classifier and its bind.
module msc_checker #(
    parameter int MAX_LEVELS = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input msc_pkg::result_t              result
);
    import msc_pkg::*;

    localparam int LATENCY = MAX_LEVELS + 2;

    // Gray value agrees with the inside flag
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.is_inside && result.gray_level == GRAY_INSIDE) ||
                  (!result.is_inside && result.gray_level == GRAY_OUTSIDE)))
    else $error("gray_level does not match is_inside");

    // Every accepted item comes out after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
    else $error("accepted item produced no result");

    // No result without an item accepted at the matching time
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

    // The pipeline takes an item every cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
    else $error("busy raised against a start");

endmodule

bind menger_section_pixel_classifier msc_checker #(
    .MAX_LEVELS (MAX_LEVELS)
) u_msc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result)
);

[tb/sv/tb_menger_section_pixel_classifier.sv]
// Self-checking testbench for the Menger section pixel classifier.
module tb_menger_section_pixel_classifier;
    import msc_pkg::*;

    localparam int MAX_LEVELS      = 8;
    localparam int PIPE_LAT        = MAX_LEVELS + 2;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int NUM_PHASES      = 15;
    localparam int ITEMS_PER_PHASE = 60;

    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [RECIP_W-1:0] RECIP_ZERO = '0;
    localparam logic [RECIP_W-1:0] RECIP_ONE  = 25'd16777216;
    localparam logic [RECIP_W-1:0] RECIP_MAX  = '1;

    // Sender idle percentage per phase, cycled
    localparam int IDLE_PCT [4] = '{0, 67, 0, 27};

    // Image sizes whose reciprocals give well-formed raster sweeps
    localparam int SIZES [15] = '{3, 4, 9, 10, 27, 28, 81, 82, 243, 244,
                                  729, 730, 2187, 2188, 4096};

    typedef enum logic [0:0] {ROW_PIXEL, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_INSIDE, CHK_OUTSIDE} row_check_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [RECIP_W-1:0]   data;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        row_check_t           chk;
    } row_t;

    localparam int NUM_ROWS = 32;
    localparam row_t DIRECTED [NUM_ROWS] = '{
        // reset settings: depth 4, pattern 0, reciprocal for size 2187
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd0,    12'd0,    CHK_INSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd4095, 12'd4095, CHK_INSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd1093, CHK_OUTSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd0,    12'd4095, CHK_MODEL},
        // depth zero: nothing examined
        '{ROW_REG,   REG_DEPTH,   25'd0,        12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd1093, CHK_INSIDE},
        // depth above the stage count saturates
        '{ROW_REG,   REG_DEPTH,   25'd15,       12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd1093, CHK_OUTSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1,    12'd2,    CHK_MODEL},
        // full pattern: one middle digit is enough
        '{ROW_REG,   REG_PATTERN, 25'd255,      12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd0,    CHK_OUTSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd0,    12'd0,    CHK_INSIDE},
        // zero scale: every fraction is zero
        '{ROW_REG,   REG_RECIP,   RECIP_ZERO,   12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd4095, 12'd4095, CHK_INSIDE},
        // largest scale: products saturate at one
        '{ROW_REG,   REG_RECIP,   RECIP_MAX,    12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1,    12'd1,    CHK_INSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd0,    12'd4095, CHK_MODEL},
        // scale of exactly one
        '{ROW_REG,   REG_RECIP,   RECIP_ONE,    12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1,    12'd0,    CHK_MODEL},
        // top pattern bit only, full depth
        '{ROW_REG,   REG_PATTERN, 25'd128,      12'd0,    12'd0,    CHK_MODEL},
        '{ROW_REG,   REG_DEPTH,   25'd8,        12'd0,    12'd0,    CHK_MODEL},
        '{ROW_REG,   REG_RECIP,   25'd7675,     12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd5,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd2048, 12'd3000, CHK_MODEL},
        // unused index leaves every register alone
        '{ROW_REG,   REG_UNUSED,  RECIP_MAX,    12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd1093, CHK_OUTSIDE},
        // upper data bits are dropped by narrow registers
        '{ROW_REG,   REG_DEPTH,   25'h1FFFFF3,  12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd2730, 12'd2730, CHK_MODEL},
        '{ROW_REG,   REG_PATTERN, 25'h1FFFF00,  12'd0,    12'd0,    CHK_MODEL},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd1093, 12'd1093, CHK_OUTSIDE},
        '{ROW_PIXEL, REG_DEPTH,   RECIP_ZERO,   12'd4095, 12'd0,    CHK_MODEL}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    pixel_t               pixel     = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RECIP_W-1:0]   cfg_data  = '0;

    // Shadow copy of the configuration
    logic [DEPTH_W-1:0]   shadow_depth   = DEPTH_RESET;
    logic [PATTERN_W-1:0] shadow_pattern = PATTERN_RESET;
    logic [RECIP_W-1:0]   shadow_recip   = RECIP_RESET;

    result_t pending_results [$];
    int      mismatches  = 0;
    int      cycle_count = 0;

    menger_section_pixel_classifier #(.MAX_LEVELS(MAX_LEVELS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Coordinate to Q1.24 fraction, saturated at one
    function automatic logic [FRAC_W-1:0] scale_coord(logic [COORD_W-1:0] c);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(c) * PROD_W'(shadow_recip);
        if (prod > PROD_W'(FRAC_ONE))
            return FRAC_ONE;
        return prod[FRAC_W-1:0];
    endfunction

    // Expected classification of one pixel under the shadow configuration
    function automatic result_t classify_pixel(pixel_t p);
        logic [FRAC_W-1:0]    fx;
        logic [FRAC_W-1:0]    fy;
        logic [FRAC_BITS+1:0] tx;
        logic [FRAC_BITS+1:0] ty;
        int                   levels;
        int                   votes;
        logic                 in_section;
        result_t              r;
        fx = scale_coord(p.pixel_x);
        fy = scale_coord(p.pixel_y);
        levels = (int'(shadow_depth) > MAX_LEVELS) ? MAX_LEVELS : int'(shadow_depth);
        in_section = 1'b1;
        for (int j = 0; j < levels; j++)
        begin
            tx = (FRAC_BITS+2)'(fx) * (FRAC_BITS+2)'(3);
            ty = (FRAC_BITS+2)'(fy) * (FRAC_BITS+2)'(3);
            votes = (j < PATTERN_W) ? int'(shadow_pattern[j]) : 0;
            if (tx[FRAC_BITS+1:FRAC_BITS] == DIGIT_MID)
                votes++;
            if (ty[FRAC_BITS+1:FRAC_BITS] == DIGIT_MID)
                votes++;
            fx = {1'b0, tx[FRAC_BITS-1:0]};
            fy = {1'b0, ty[FRAC_BITS-1:0]};
            if (votes >= 2)
            begin
                in_section = 1'b0;
                break;
            end
        end
        r.is_inside  = in_section;
        r.gray_level = in_section ? GRAY_INSIDE : GRAY_OUTSIDE;
        return r;
    endfunction

    // Present one pixel, wait for it to be taken, record its expectation
    task automatic send_pixel(pixel_t p, int idle_pct, row_check_t chk);
        bit      took;
        result_t want;
        took = 1'b0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        while (!took)
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        case (chk)
            CHK_INSIDE:  want = '{is_inside: 1'b1, gray_level: GRAY_INSIDE};
            CHK_OUTSIDE: want = '{is_inside: 1'b0, gray_level: GRAY_OUTSIDE};
            default:     want = classify_pixel(p);
        endcase
        pending_results.push_back(want);
    endtask

    // Stop sending and let the pipeline empty
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // One register write; the shadow copy follows
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RECIP_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_DEPTH:   shadow_depth   = data[DEPTH_W-1:0];
            REG_PATTERN: shadow_pattern = data[PATTERN_W-1:0];
            REG_RECIP:   shadow_recip   = data;
            default:     ;
        endcase
        @(posedge clk);
    endtask

    // Result checker: outputs are stable at the falling edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: is_inside=%0d gray_level=%0d",
                       result.is_inside, result.gray_level);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.is_inside !== want.is_inside)
                begin
                    $error("is_inside: expected %0d, got %0d", want.is_inside,
                           result.is_inside);
                    mismatches++;
                end
                if (result.gray_level !== want.gray_level)
                begin
                    $error("gray_level: expected %0d, got %0d", want.gray_level,
                           result.gray_level);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("** menger_section_pixel_classifier: FAILED **");
            $finish;
        end
    end

    initial
    begin
        pixel_t             p;
        logic [RECIP_W-1:0] data;
        int                 size_sel;
        int                 coord_hi;
        int                 idle_pct;
        int                 pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                drain_pipeline();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                p.pixel_x = DIRECTED[i].x;
                p.pixel_y = DIRECTED[i].y;
                send_pixel(p, 0, DIRECTED[i].chk);
            end
        end

        // Random phases, each with its own settings and idle rate
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_pipeline();

            // depth mostly in the useful range, upper data bits random
            data = RECIP_W'($urandom);
            if ($urandom_range(0, 4) != 0)
                data[DEPTH_W-1:0] = DEPTH_W'($urandom_range(1, MAX_LEVELS));
            write_reg(REG_DEPTH, data);
            write_reg(REG_PATTERN, RECIP_W'($urandom));

            // scale: mostly a real image size, some extremes and noise
            pick = $urandom_range(0, 99);
            coord_hi = 4095;
            if (pick < 75)
            begin
                size_sel = $urandom_range(0, 14);
                coord_hi = SIZES[size_sel] - 1;
                data = RECIP_W'((64'd16777216 + 64'(coord_hi / 2)) / 64'(coord_hi));
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       data = RECIP_ZERO;
                    1:       data = 25'd1;
                    2:       data = RECIP_ONE;
                    default: data = RECIP_MAX;
                endcase
            end
            else
                data = RECIP_W'($urandom);
            write_reg(REG_RECIP, data);

            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, RECIP_W'($urandom));

            idle_pct = IDLE_PCT[ph % 4];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    p.pixel_x = COORD_W'($urandom_range(0, coord_hi));
                    p.pixel_y = COORD_W'($urandom_range(0, coord_hi));
                end
                else
                begin
                    p.pixel_x = COORD_W'($urandom);
                    p.pixel_y = COORD_W'($urandom);
                end
                send_pixel(p, idle_pct, CHK_MODEL);
            end
        end

        drain_pipeline();
        repeat (PIPE_LAT) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("** menger_section_pixel_classifier: PASSED **");
        else
            $display("** menger_section_pixel_classifier: FAILED **");
        $finish;
    end

endmodule
